/* rtl/lcs_pkg.sv */
package lcs_pkg;

  typedef enum logic [1:0] {
    STA_PROV,
    STA_CONNECTING,
    STA_ONLINE,
    STA_RETRY
  } lcs_sta_t;

  typedef enum logic [1:0] {
    AP_INACTIVE,
    AP_ACTIVE,
    AP_RETRY
  } lcs_ap_t;

  typedef enum logic [1:0] {
    MODE_INIT,
    MODE_POLL,
    MODE_DISC
  } lcs_mode_t;

  localparam logic [1:0] RADIO_OFF  = 2'd0;
  localparam logic [1:0] RADIO_STA  = 2'd1;
  localparam logic [1:0] RADIO_AP   = 2'd2;
  localparam logic [1:0] RADIO_BOTH = 2'd3;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_FATAL    = 2'd1;
  localparam logic [1:0] CAUSE_DEADLINE = 2'd2;

  localparam logic [2:0] NOTE_NONE       = 3'd0;
  localparam logic [2:0] NOTE_CONNECTING = 3'd1;
  localparam logic [2:0] NOTE_CONNECTED  = 3'd2;
  localparam logic [2:0] NOTE_ERROR      = 3'd3;
  localparam logic [2:0] NOTE_DISABLED   = 3'd4;

  localparam logic [2:0] CFG_HAS_CREDENTIALS = 3'd0;
  localparam logic [2:0] CFG_ATTEMPT_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_RECONNECT       = 3'd2;
  localparam logic [2:0] CFG_FALLBACK_DELAY  = 3'd3;
  localparam logic [2:0] CFG_AP_RETRY        = 3'd4;
  localparam logic [2:0] CFG_AP_IDLE         = 3'd5;

  localparam logic [31:0] RST_ATTEMPT_TIMEOUT = 32'd15000;
  localparam logic [31:0] RST_RECONNECT       = 32'd10000;
  localparam logic [31:0] RST_FALLBACK_DELAY  = 32'd60000;
  localparam logic [31:0] RST_AP_RETRY        = 32'd5000;
  localparam logic [31:0] RST_AP_IDLE         = 32'd300000;

  localparam logic [15:0] FATAL_R0 = 16'd2;
  localparam logic [15:0] FATAL_R1 = 16'd4;
  localparam logic [15:0] FATAL_R2 = 16'd15;
  localparam logic [15:0] FATAL_R3 = 16'd23;
  localparam logic [15:0] FATAL_R4 = 16'd201;
  localparam logic [15:0] FATAL_R5 = 16'd202;
  localparam logic [15:0] FATAL_R6 = 16'd203;
  localparam logic [15:0] FATAL_R7 = 16'd204;

  typedef struct packed {
    logic        has_credentials;
    logic [31:0] attempt_timeout_ms;
    logic [31:0] reconnect_interval_ms;
    logic [31:0] fallback_delay_ms;
    logic [31:0] ap_retry_interval_ms;
    logic [31:0] ap_idle_timeout_ms;
  } lcs_cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic        sta_link_up;
    logic        ap_clients_present;
    logic        ap_start_ok;
    logic [15:0] disconnect_reason;
  } lcs_item_t;

  typedef struct packed {
    lcs_sta_t    sta;
    lcs_ap_t     ap;
    logic [1:0]  radio;
    logic        campaign;
    logic        fallback;
    logic        accepting;
    logic        pend_valid;
    logic [15:0] pend_reason;
    logic [31:0] pend_attempt;
    logic [31:0] active_attempt;
    logic [31:0] next_attempt;
    logic [31:0] connect_t;
    logic [31:0] retry_t;
    logic [31:0] campaign_t;
    logic [31:0] ap_idle_t;
    logic [31:0] ap_retry_t;
  } lcs_state_t;

  typedef struct packed {
    logic [1:0]  sta_status;
    logic [1:0]  ap_status;
    logic [1:0]  radio_mode;
    logic        begin_connect;
    logic        drop_link;
    logic        ap_bring_up;
    logic        ap_take_down;
    logic [1:0]  failure_cause;
    logic [2:0]  notify;
    logic [31:0] attempt_number;
  } lcs_result_t;

  function automatic logic elapsed(input logic [31:0] now_ms, input logic [31:0] start,
                                   input logic [31:0] interval);
    logic [31:0] diff;
    diff = now_ms - start;
    return diff >= interval;
  endfunction

  function automatic logic is_fatal(input logic [15:0] r);
    return (r == FATAL_R0) || (r == FATAL_R1) || (r == FATAL_R2) || (r == FATAL_R3) ||
           (r == FATAL_R4) || (r == FATAL_R5) || (r == FATAL_R6) || (r == FATAL_R7);
  endfunction

endpackage

/* rtl/link_connection_supervisor_core.sv */
// Station link supervisor with fallback access point. Each input transfer is an init, poll
// tick or disconnect event (in_tuser) with a 32-bit ms time and status flags; each one
// yields exactly one result transfer showing the station and AP state after the event,
// the command pulses, the failure cause, a notify code and the active attempt number.
// Each event passes through an input register, then a result register, and one item is
// taken every cycle while the output is not stalled: the whole event update is one
// combinational pass over the state registers. Configuration writes are taken at any time
// and should only be issued while no event is in flight.
module link_connection_supervisor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  // now_ms[31:0], sta_link_up[32], ap_clients_present[33], ap_start_ok[34],
  // disconnect_reason[50:35], zero[55:51]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sta_status[1:0], ap_status[3:2], radio_mode[5:4], begin_connect[6], drop_link[7],
  // ap_bring_up[8], ap_take_down[9], failure_cause[11:10], notify[14:12],
  // attempt_number[46:15], zero[47]
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  lcs_pkg::lcs_cfg_t    cfg_r;
  lcs_pkg::lcs_state_t  st_r;
  lcs_pkg::lcs_state_t  st_nxt;
  lcs_pkg::lcs_item_t   s1_item_r;
  lcs_pkg::lcs_item_t   item_nxt;
  lcs_pkg::lcs_result_t res_nxt;
  lcs_pkg::lcs_result_t out_res_r;
  logic                 s1_valid_r;
  logic                 out_valid_r;
  logic                 adv;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    item_nxt.mode               = in_tuser;
    item_nxt.now_ms             = in_tdata[31:0];
    item_nxt.sta_link_up        = in_tdata[32];
    item_nxt.ap_clients_present = in_tdata[33];
    item_nxt.ap_start_ok        = in_tdata[34];
    item_nxt.disconnect_reason  = in_tdata[50:35];
  end

  lcs_step u_step (
    .cfg    (cfg_r),
    .item   (s1_item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.has_credentials       <= 1'b0;
      cfg_r.attempt_timeout_ms    <= lcs_pkg::RST_ATTEMPT_TIMEOUT;
      cfg_r.reconnect_interval_ms <= lcs_pkg::RST_RECONNECT;
      cfg_r.fallback_delay_ms     <= lcs_pkg::RST_FALLBACK_DELAY;
      cfg_r.ap_retry_interval_ms  <= lcs_pkg::RST_AP_RETRY;
      cfg_r.ap_idle_timeout_ms    <= lcs_pkg::RST_AP_IDLE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lcs_pkg::CFG_HAS_CREDENTIALS: cfg_r.has_credentials       <= cfg_data[0];
        lcs_pkg::CFG_ATTEMPT_TIMEOUT: cfg_r.attempt_timeout_ms    <= cfg_data;
        lcs_pkg::CFG_RECONNECT:       cfg_r.reconnect_interval_ms <= cfg_data;
        lcs_pkg::CFG_FALLBACK_DELAY:  cfg_r.fallback_delay_ms     <= cfg_data;
        lcs_pkg::CFG_AP_RETRY:        cfg_r.ap_retry_interval_ms  <= cfg_data;
        lcs_pkg::CFG_AP_IDLE:         cfg_r.ap_idle_timeout_ms    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // all-zero state is provisioning, AP inactive, radio off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (adv) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_item_r <= item_nxt;
    if (adv && s1_valid_r) out_res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.attempt_number, out_res_r.notify,
                       out_res_r.failure_cause, out_res_r.ap_take_down, out_res_r.ap_bring_up,
                       out_res_r.drop_link, out_res_r.begin_connect, out_res_r.radio_mode,
                       out_res_r.ap_status, out_res_r.sta_status};

endmodule

/* rtl/lcs_step.sv */
module lcs_step (
  input  lcs_pkg::lcs_cfg_t    cfg,
  input  lcs_pkg::lcs_item_t   item,
  input  lcs_pkg::lcs_state_t  st,
  output lcs_pkg::lcs_state_t  st_nxt,
  output lcs_pkg::lcs_result_t res
);

  typedef struct packed {
    lcs_pkg::lcs_state_t s;
    logic                begin_c;
    logic                drop;
    logic                up;
    logic                down;
    logic [1:0]          cause;
    logic [2:0]          note;
  } work_t;

  function automatic work_t request_ap(input work_t w, input lcs_pkg::lcs_item_t it);
    work_t r;
    r = w;
    if (r.s.ap != lcs_pkg::AP_ACTIVE) begin
      if (it.ap_start_ok) begin
        r.s.ap = lcs_pkg::AP_ACTIVE;
        r.s.ap_idle_t = it.now_ms;
        r.up = 1'b1;
      end else begin
        r.s.ap = lcs_pkg::AP_RETRY;
        r.s.ap_retry_t = it.now_ms;
      end
    end
    return r;
  endfunction

  function automatic work_t stop_ap(input work_t w, input lcs_pkg::lcs_cfg_t c);
    work_t r;
    r = w;
    if (r.s.ap != lcs_pkg::AP_INACTIVE) begin
      if (r.s.ap == lcs_pkg::AP_ACTIVE) r.down = 1'b1;
      r.s.ap = lcs_pkg::AP_INACTIVE;
      r.s.radio = c.has_credentials ? lcs_pkg::RADIO_STA : lcs_pkg::RADIO_OFF;
    end
    return r;
  endfunction

  function automatic work_t start_campaign(input work_t w, input lcs_pkg::lcs_item_t it);
    work_t r;
    r = w;
    r.s.campaign = 1'b1;
    r.s.fallback = 1'b0;
    r.s.campaign_t = it.now_ms;
    return r;
  endfunction

  function automatic work_t start_connection(input work_t w, input lcs_pkg::lcs_cfg_t c,
                                             input lcs_pkg::lcs_item_t it);
    work_t r;
    r = w;
    if (r.s.sta != lcs_pkg::STA_CONNECTING) begin
      if (!c.has_credentials) begin
        r.s.sta = lcs_pkg::STA_PROV;
      end else begin
        r.note = lcs_pkg::NOTE_CONNECTING;
        r.s.pend_valid = 1'b0;
        r.s.next_attempt = r.s.next_attempt + 32'd1;
        r.s.active_attempt = r.s.next_attempt;
        r.s.connect_t = it.now_ms;
        r.s.sta = lcs_pkg::STA_CONNECTING;
        r.s.accepting = 1'b1;
        r.begin_c = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic work_t on_connected(input work_t w, input lcs_pkg::lcs_cfg_t c);
    work_t r;
    r = w;
    r.s.accepting = 1'b0;
    r.s.pend_valid = 1'b0;
    r.s.sta = lcs_pkg::STA_ONLINE;
    r.s.campaign = 1'b0;
    r = stop_ap(r, c);
    r.note = lcs_pkg::NOTE_CONNECTED;
    r.s.next_attempt = '0;
    r.s.active_attempt = '0;
    return r;
  endfunction

  function automatic work_t fail_connection(input work_t w, input logic [1:0] cause,
                                            input lcs_pkg::lcs_item_t it);
    work_t r;
    r = w;
    r.s.accepting = 1'b0;
    r.s.pend_valid = 1'b0;
    r.s.sta = lcs_pkg::STA_RETRY;
    r.s.retry_t = it.now_ms;
    if (cause == lcs_pkg::CAUSE_DEADLINE) r.drop = 1'b1;
    r.cause = cause;
    r.note = lcs_pkg::NOTE_ERROR;
    return r;
  endfunction

  function automatic work_t check_connecting(input work_t w, input lcs_pkg::lcs_cfg_t c,
                                             input lcs_pkg::lcs_item_t it);
    work_t r;
    logic  failed;
    r = w;
    failed = 1'b0;
    if (it.sta_link_up) begin
      r = on_connected(r, c);
    end else begin
      if (r.s.pend_valid && (r.s.pend_attempt == r.s.active_attempt)) begin
        r.s.pend_valid = 1'b0;
        if (lcs_pkg::is_fatal(r.s.pend_reason)) begin
          r = fail_connection(r, lcs_pkg::CAUSE_FATAL, it);
          failed = 1'b1;
        end
      end
      if (!failed && lcs_pkg::elapsed(it.now_ms, r.s.connect_t, c.attempt_timeout_ms)) begin
        r = fail_connection(r, lcs_pkg::CAUSE_DEADLINE, it);
      end
    end
    return r;
  endfunction

  function automatic work_t check_fallback(input work_t w, input lcs_pkg::lcs_cfg_t c,
                                           input lcs_pkg::lcs_item_t it);
    work_t r;
    r = w;
    if (r.s.campaign && !r.s.fallback && !it.sta_link_up &&
        lcs_pkg::elapsed(it.now_ms, r.s.campaign_t, c.fallback_delay_ms)) begin
      r.s.fallback = 1'b1;
      r.s.radio = lcs_pkg::RADIO_BOTH;
      r = request_ap(r, it);
    end
    return r;
  endfunction

  function automatic work_t check_retry_wait(input work_t w, input lcs_pkg::lcs_cfg_t c,
                                             input lcs_pkg::lcs_item_t it);
    work_t r;
    r = w;
    if (it.sta_link_up) begin
      r = on_connected(r, c);
    end else if (lcs_pkg::elapsed(it.now_ms, r.s.retry_t, c.reconnect_interval_ms)) begin
      r = start_connection(r, c, it);
    end
    return r;
  endfunction

  work_t w;

  always_comb begin
    w = '0;
    w.s = st;
    w.cause = lcs_pkg::CAUSE_NONE;
    w.note = lcs_pkg::NOTE_NONE;
    unique case (lcs_pkg::lcs_mode_t'(item.mode))
      lcs_pkg::MODE_INIT: begin
        if (!cfg.has_credentials) begin
          w.s.radio = lcs_pkg::RADIO_AP;
          w = request_ap(w, item);
          w.s.sta = lcs_pkg::STA_PROV;
          w.note = lcs_pkg::NOTE_DISABLED;
        end else begin
          w.s.radio = lcs_pkg::RADIO_STA;
          w = start_campaign(w, item);
          w = start_connection(w, cfg, item);
        end
      end
      lcs_pkg::MODE_POLL: begin
        unique case (w.s.sta)
          lcs_pkg::STA_CONNECTING: begin
            w = check_connecting(w, cfg, item);
            w = check_fallback(w, cfg, item);
          end
          lcs_pkg::STA_ONLINE: begin
            if (!item.sta_link_up) begin
              w.drop = 1'b1;
              w = start_campaign(w, item);
              w.s.sta = lcs_pkg::STA_RETRY;
              w.s.retry_t = item.now_ms;
            end
          end
          lcs_pkg::STA_RETRY: begin
            w = check_fallback(w, cfg, item);
            w = check_retry_wait(w, cfg, item);
          end
          default: begin
          end
        endcase
        if ((w.s.sta != lcs_pkg::STA_ONLINE) && !item.sta_link_up &&
            (w.s.ap == lcs_pkg::AP_RETRY) &&
            lcs_pkg::elapsed(item.now_ms, w.s.ap_retry_t, cfg.ap_retry_interval_ms)) begin
          w = request_ap(w, item);
        end
        if (cfg.has_credentials && w.s.campaign && !item.sta_link_up &&
            (w.s.ap == lcs_pkg::AP_ACTIVE)) begin
          if (item.ap_clients_present) begin
            w.s.ap_idle_t = item.now_ms;
          end else if (lcs_pkg::elapsed(item.now_ms, w.s.ap_idle_t,
                                        cfg.ap_idle_timeout_ms)) begin
            w = stop_ap(w, cfg);
          end
        end
      end
      lcs_pkg::MODE_DISC: begin
        if ((w.s.sta == lcs_pkg::STA_CONNECTING) && w.s.accepting && !w.s.pend_valid) begin
          w.s.pend_valid = 1'b1;
          w.s.pend_attempt = w.s.active_attempt;
          w.s.pend_reason = item.disconnect_reason;
        end
      end
      default: begin
      end
    endcase
  end

  assign st_nxt = w.s;

  always_comb begin
    res.sta_status     = w.s.sta;
    res.ap_status      = w.s.ap;
    res.radio_mode     = w.s.radio;
    res.begin_connect  = w.begin_c;
    res.drop_link      = w.drop;
    res.ap_bring_up    = w.up;
    res.ap_take_down   = w.down;
    res.failure_cause  = w.cause;
    res.notify         = w.note;
    res.attempt_number = w.s.active_attempt;
  end

endmodule

/* rtl/lcs_checker.sv */
module lcs_props (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:2] != 2'd3) && (out_tdata[11:10] != 2'd3) &&
                   (out_tdata[14:12] <= lcs_pkg::NOTE_DISABLED) && !out_tdata[47])
    else $error("result carries an unused code");

  a_begin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |->
      (out_tdata[1:0] == lcs_pkg::STA_CONNECTING) &&
      (out_tdata[14:12] == lcs_pkg::NOTE_CONNECTING))
    else $error("connect issued without connecting state");

  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:10] != lcs_pkg::CAUSE_NONE) |->
      (out_tdata[1:0] == lcs_pkg::STA_RETRY) && (out_tdata[14:12] == lcs_pkg::NOTE_ERROR) &&
      (out_tdata[7] == (out_tdata[11:10] == lcs_pkg::CAUSE_DEADLINE)))
    else $error("failure reported outside retry wait");

endmodule

bind link_connection_supervisor_core lcs_props u_lcs_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
